FILE: hw/rtl/msit_pkg.sv
package msit_pkg;

  localparam logic [3:0] CMD_TICK    = 4'd0;
  localparam logic [3:0] CMD_SETUP   = 4'd1;
  localparam logic [3:0] CMD_CHANGE  = 4'd2;
  localparam logic [3:0] CMD_DELETE  = 4'd3;
  localparam logic [3:0] CMD_RESTART = 4'd4;
  localparam logic [3:0] CMD_ENABLE  = 4'd5;
  localparam logic [3:0] CMD_DISABLE = 4'd6;
  localparam logic [3:0] CMD_TOGGLE  = 4'd7;
  localparam logic [3:0] CMD_ENA_ALL = 4'd8;
  localparam logic [3:0] CMD_DIS_ALL = 4'd9;
  localparam logic [3:0] CMD_QUERY   = 4'd10;

  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] interval_ms;
    logic [15:0] run_limit;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] result_slot;
    logic       ok;
    logic       slot_enabled;
    logic [4:0] active_count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [31:0] ival;
    logic [31:0] last_time;
    logic [15:0] lim;
    logic [15:0] cnt;
  } entry_t;

endpackage

FILE: hw/rtl/msit_rem.sv
module msit_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] rem
);

  logic [31:0] r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] q;
  logic [4:0]  cnt;
  logic        run;

  assign trial = {r, q[31]};
  assign diff  = trial - {1'b0, den};
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        r   <= '0;
        q   <= num;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (trial >= {1'b0, den}) begin
          r <= diff[31:0];
        end else begin
          r <= trial[31:0];
        end
        q   <= {q[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/msit_mem.sv
module msit_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  msit_pkg::entry_t      wdata,
  input  logic [AW-1:0]         raddr,
  output msit_pkg::entry_t      rdata
);

  msit_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/multi_slot_interval_timer_table.sv
// Table of NUM_SLOTS interval timers. An item is taken when start is high and
// busy is low; busy falls in the cycle that shows the last result of the item.
// Results appear one per cycle on result, marked by valid, and must be taken
// then: the receiver cannot stall. A command other than tick has a read state
// and a write-back state. A tick walks every slot through the slot memory (one
// read, one write port): read only for an unused slot, read and check for a used
// one not due, and also an update for a due one (32-step remainder unit first
// at two or more intervals past); then fire reporting per slot and the done result.
module multi_slot_interval_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  msit_pkg::cmd_t   cmd_item,
  output logic             valid,
  output msit_pkg::res_t   result
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CWB  = 4'd2;
  localparam logic [3:0] S_TRD  = 4'd3;
  localparam logic [3:0] S_TCHK = 4'd4;
  localparam logic [3:0] S_TDIV = 4'd5;
  localparam logic [3:0] S_TUPD = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]            state;
  msit_pkg::cmd_t        item;
  logic [IW-1:0]         idx;
  logic                  inr;
  logic [NUM_SLOTS-1:0]  used;
  logic [NUM_SLOTS-1:0]  en;
  logic [NUM_SLOTS-1:0]  cz;
  logic [NUM_SLOTS-1:0][1:0] kinds;
  logic [CW-1:0]         used_count;
  logic [31:0]           rem;

  logic [6:0]            slot_ext;
  logic                  inr_in;
  logic [IW-1:0]         idx_in;
  logic                  used_s;
  logic                  free_found;
  logic [IW-1:0]         free_idx;

  msit_pkg::entry_t      rd;
  msit_pkg::entry_t      wd;
  logic                  we;
  logic [IW-1:0]         waddr;

  logic [31:0]           el;
  logic [31:0]           el_m;
  logic                  div_go;
  logic                  div_done;
  logic [31:0]           div_rem;

  logic [15:0]           cnt_inc;
  logic [1:0]            knew;
  logic [CW-1:0]         cnt_after;
  logic [7:0]            cnt_w;
  logic [7:0]            idx_w;
  logic [7:0]            free_w;

  assign busy     = (state != S_IDLE);
  assign slot_ext = {3'b000, cmd_item.slot};
  assign inr_in   = (slot_ext < 7'(NUM_SLOTS));
  assign idx_in   = inr_in ? slot_ext[IW-1:0] : '0;
  assign used_s   = inr & used[idx];
  assign el       = item.now_ms - rd.last_time;
  assign el_m     = el - rd.ival;
  assign cnt_inc  = rd.cnt + 16'd1;
  assign idx_w    = 8'(idx);
  assign free_w   = 8'(free_idx);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    knew = msit_pkg::KIND_ANSWER;
    if (en[idx]) begin
      if (rd.lim == 16'd0) begin
        knew = msit_pkg::KIND_FIRED;
      end else if (rd.cnt < rd.lim) begin
        knew = (cnt_inc >= rd.lim) ? msit_pkg::KIND_REMOVE : msit_pkg::KIND_FIRED;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wd    = rd;
    if (state == S_CWB) begin
      case (item.cmd)
        msit_pkg::CMD_SETUP: begin
          we    = free_found;
          waddr = free_idx;
          wd    = '{ival: item.interval_ms, last_time: item.now_ms,
                    lim: item.run_limit, cnt: 16'd0};
        end
        msit_pkg::CMD_CHANGE: begin
          we           = used_s;
          wd.ival      = item.interval_ms;
          wd.last_time = item.now_ms;
        end
        msit_pkg::CMD_RESTART: begin
          we           = inr;
          wd.last_time = item.now_ms;
        end
        default: we = 1'b0;
      endcase
    end else if (state == S_TUPD) begin
      we           = 1'b1;
      wd.last_time = item.now_ms - rem;
      if (en[idx] && rd.lim != 16'd0 && rd.cnt < rd.lim) begin
        wd.cnt = cnt_inc;
      end
    end
  end

  always_comb begin
    cnt_after = used_count;
    if (state == S_CWB) begin
      if (item.cmd == msit_pkg::CMD_SETUP && free_found) begin
        cnt_after = used_count + CW'(1);
      end else if (item.cmd == msit_pkg::CMD_DELETE && used_s) begin
        cnt_after = used_count - CW'(1);
      end
    end else if (state == S_TUPD && knew == msit_pkg::KIND_REMOVE) begin
      cnt_after = used_count - CW'(1);
    end
  end

  assign cnt_w  = 8'(cnt_after);
  assign div_go = (state == S_TCHK) && rd.ival != 32'd0 && el >= rd.ival
                  && el_m >= rd.ival;

  msit_mem #(.DEPTH(NUM_SLOTS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd),
    .raddr (idx),
    .rdata (rd)
  );

  msit_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (el),
    .den  (rd.ival),
    .done (div_done),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      en         <= '0;
      cz         <= '0;
      used_count <= '0;
      valid      <= 1'b0;
      idx        <= '0;
    end else begin
      valid      <= 1'b0;
      used_count <= cnt_after;
      result.kind         <= msit_pkg::KIND_ANSWER;
      result.result_slot  <= 4'd0;
      result.ok           <= 1'b1;
      result.slot_enabled <= 1'b0;
      result.active_count <= cnt_w[4:0];
      result.last         <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item <= cmd_item;
            inr  <= inr_in;
            if (cmd_item.cmd == msit_pkg::CMD_TICK) begin
              idx   <= '0;
              state <= S_TRD;
            end else begin
              idx   <= idx_in;
              state <= S_CRD;
            end
          end
        end
        S_CRD: state <= S_CWB;
        S_CWB: begin
          valid       <= 1'b1;
          result.last <= 1'b1;
          result.ok   <= used_s;
          case (item.cmd)
            msit_pkg::CMD_SETUP: begin
              result.ok <= free_found;
              if (free_found) begin
                result.result_slot <= free_w[3:0];
                used[free_idx]     <= 1'b1;
                en[free_idx]       <= 1'b1;
                cz[free_idx]       <= 1'b1;
              end
            end
            msit_pkg::CMD_DELETE: begin
              if (used_s) begin
                used[idx] <= 1'b0;
                en[idx]   <= 1'b0;
                cz[idx]   <= 1'b0;
              end
            end
            msit_pkg::CMD_ENABLE:  if (inr) en[idx] <= 1'b1;
            msit_pkg::CMD_DISABLE: if (inr) en[idx] <= 1'b0;
            msit_pkg::CMD_TOGGLE:  if (inr) en[idx] <= ~en[idx];
            msit_pkg::CMD_ENA_ALL, msit_pkg::CMD_DIS_ALL: begin
              result.ok <= 1'b1;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (used[i] && cz[i]) begin
                  en[i] <= (item.cmd == msit_pkg::CMD_ENA_ALL);
                end
              end
            end
            msit_pkg::CMD_QUERY: result.slot_enabled <= inr & en[idx];
            msit_pkg::CMD_CHANGE, msit_pkg::CMD_RESTART: ;
            default: result.ok <= 1'b0;
          endcase
          state <= S_IDLE;
        end
        S_TRD: begin
          if (used[idx]) begin
            state <= S_TCHK;
          end else begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) kinds[i] <= kinds[i+1];
            kinds[NUM_SLOTS-1] <= msit_pkg::KIND_ANSWER;
            idx   <= (idx == LAST_IDX) ? '0 : idx + IW'(1);
            state <= (idx == LAST_IDX) ? S_EMIT : S_TRD;
          end
        end
        S_TCHK: begin
          if (rd.ival == 32'd0) begin
            rem   <= 32'd0;
            state <= S_TUPD;
          end else if (el < rd.ival) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) kinds[i] <= kinds[i+1];
            kinds[NUM_SLOTS-1] <= msit_pkg::KIND_ANSWER;
            idx   <= (idx == LAST_IDX) ? '0 : idx + IW'(1);
            state <= (idx == LAST_IDX) ? S_EMIT : S_TRD;
          end else if (el_m < rd.ival) begin
            rem   <= el_m;
            state <= S_TUPD;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            rem   <= div_rem;
            state <= S_TUPD;
          end
        end
        S_TUPD: begin
          if (knew != msit_pkg::KIND_ANSWER && rd.lim != 16'd0) begin
            cz[idx] <= 1'b0;
          end
          if (knew == msit_pkg::KIND_REMOVE) begin
            used[idx]  <= 1'b0;
            en[idx]    <= 1'b0;
          end
          for (int i = 0; i < NUM_SLOTS - 1; i++) kinds[i] <= kinds[i+1];
          kinds[NUM_SLOTS-1] <= knew;
          idx   <= (idx == LAST_IDX) ? '0 : idx + IW'(1);
          state <= (idx == LAST_IDX) ? S_EMIT : S_TRD;
        end
        S_EMIT: begin
          if (kinds[0] != msit_pkg::KIND_ANSWER) begin
            valid              <= 1'b1;
            result.kind        <= kinds[0];
            result.result_slot <= idx_w[3:0];
          end
          for (int i = 0; i < NUM_SLOTS - 1; i++) kinds[i] <= kinds[i+1];
          kinds[NUM_SLOTS-1] <= msit_pkg::KIND_ANSWER;
          idx   <= (idx == LAST_IDX) ? '0 : idx + IW'(1);
          state <= (idx == LAST_IDX) ? S_DONE : S_EMIT;
        end
        S_DONE: begin
          valid       <= 1'b1;
          result.kind <= msit_pkg::KIND_DONE;
          result.last <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
